>>> src/bpe_pkg.sv
// shared types and constants for the binary polynomial extended euclid unit
package bpe_pkg;

    localparam int POLY_WIDTH = 16;
    localparam int DEG_W      = $clog2(POLY_WIDTH);

    typedef logic [POLY_WIDTH-1:0] t_poly;
    typedef logic [DEG_W-1:0]      t_deg;

    typedef struct packed {
        t_poly op_a;
        t_poly op_b;
    } t_in;

    typedef struct packed {
        t_poly gcd_poly;
        t_poly coef_a;
        t_poly coef_b;
        t_poly inverse;
        logic  has_inverse;
        logic  div_zero;
    } t_out;

    typedef struct packed {
        logic reduce;
        logic rem_zero;
    } t_step_ctl;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

endpackage

>>> src/bpe_step.sv
// one shift-xor reduction step of the division, with matching coefficient updates
module bpe_step (
    input  bpe_pkg::t_poly     i_rem,
    input  bpe_pkg::t_poly     i_den,
    input  bpe_pkg::t_poly     i_s0,
    input  bpe_pkg::t_poly     i_t0,
    input  bpe_pkg::t_poly     i_s1,
    input  bpe_pkg::t_poly     i_t1,
    output bpe_pkg::t_step_ctl o_ctl,
    output bpe_pkg::t_poly     o_rem,
    output bpe_pkg::t_poly     o_s0,
    output bpe_pkg::t_poly     o_t0
);

    // position of the leading one, zero for an all-zero word
    function automatic bpe_pkg::t_deg deg_of(input bpe_pkg::t_poly v);
        bpe_pkg::t_deg d;
        d = '0;
        for (int i = 0; i < bpe_pkg::POLY_WIDTH; i++) begin
            if (v[i]) begin
                d = bpe_pkg::DEG_W'(i);
            end
        end
        return d;
    endfunction

    bpe_pkg::t_deg deg_rem;
    bpe_pkg::t_deg deg_den;
    bpe_pkg::t_deg sh;

    always_comb begin
        deg_rem          = deg_of(i_rem);
        deg_den          = deg_of(i_den);
        sh               = deg_rem - deg_den;
        o_ctl.rem_zero   = (i_rem == '0);
        o_ctl.reduce     = !o_ctl.rem_zero && (deg_rem >= deg_den);
        o_rem            = i_rem ^ (i_den << sh);
        // quotient bit at sh folds straight into the coefficients, truncated to width
        o_s0             = i_s0 ^ (i_s1 << sh);
        o_t0             = i_t0 ^ (i_t1 << sh);
    end

endmodule

>>> src/binary_poly_ext_euclid_inverse_unit.sv
// top level: extended euclid over gf(2) polynomials with modular inverse
//
// input channel i_in_valid / i_in_data / o_in_stall carries op_a and op_b;
// an item is taken on a clock edge with valid high and stall low.
// output channel o_out_valid / o_out_data / i_out_stall returns one item
// per input item: gcd, bezout coefficients, inverse and the two flags.
// o_in_stall is high during reset and while an item is being worked on; the
// unit takes a new item in the cycle after the previous result has been
// handed to the output register, even while that result still waits.
// each cycle of work does one shift-xor reduction of the remainder, with
// the coefficient updates done in the same step, or one swap of the
// remainder into the divisor; when the division ends, the result is loaded
// into the output register, with no reduction or swap when op_b is zero.
// the leading-one search and barrel shift in bpe_step set the cycle time.
// reset (synchronous, active low) clears the output valid and returns to idle.
// while the receiver stalls, the result stays on o_out_data and a finished
// computation waits in the run state until the output register frees up.
module binary_poly_ext_euclid_inverse_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  bpe_pkg::t_in    i_in_data,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output bpe_pkg::t_out   o_out_data,
    input  logic            i_out_stall
);

    bpe_pkg::t_state    r_state, n_state;
    bpe_pkg::t_poly     r_rem, r_den, r_s0, r_t0, r_s1, r_t1;
    logic               r_dz;
    logic               r_out_valid, n_out_valid;
    bpe_pkg::t_out      r_out, n_out;

    bpe_pkg::t_step_ctl step_ctl;
    bpe_pkg::t_poly     step_rem, step_s0, step_t0;

    logic               in_take;
    logic               out_free;
    logic               done;

    bpe_step u_step (
        .i_rem (r_rem),
        .i_den (r_den),
        .i_s0  (r_s0),
        .i_t0  (r_t0),
        .i_s1  (r_s1),
        .i_t1  (r_t1),
        .o_ctl (step_ctl),
        .o_rem (step_rem),
        .o_s0  (step_s0),
        .o_t0  (step_t0)
    );

    assign o_in_stall  = (r_state != bpe_pkg::S_IDLE) || !i_rst_n;
    assign in_take     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    // division finished with zero remainder (divisor is the gcd), or op_b was zero
    assign done        = (r_state == bpe_pkg::S_RUN)
                         && (r_dz || (!step_ctl.reduce && step_ctl.rem_zero));
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            bpe_pkg::S_IDLE: begin
                if (in_take) begin
                    n_state = bpe_pkg::S_RUN;
                end
            end
            bpe_pkg::S_RUN: begin
                if (done && out_free) begin
                    n_state     = bpe_pkg::S_IDLE;
                    n_out_valid = 1'b1;
                    if (r_dz) begin
                        n_out          = '0;
                        n_out.div_zero = 1'b1;
                    end else begin
                        n_out.gcd_poly    = r_den;
                        n_out.coef_a      = r_s1;
                        n_out.coef_b      = r_t1;
                        n_out.has_inverse = (r_den == bpe_pkg::POLY_WIDTH'(1));
                        n_out.inverse     = n_out.has_inverse ? r_s1 : '0;
                        n_out.div_zero    = 1'b0;
                    end
                end
            end
            default: begin
                n_state = bpe_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bpe_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (in_take) begin
            r_rem <= i_in_data.op_a;
            r_den <= i_in_data.op_b;
            r_s0  <= bpe_pkg::POLY_WIDTH'(1);
            r_t0  <= '0;
            r_s1  <= '0;
            r_t1  <= bpe_pkg::POLY_WIDTH'(1);
            r_dz  <= (i_in_data.op_b == '0);
        end else if (r_state == bpe_pkg::S_RUN && !done) begin
            if (step_ctl.reduce) begin
                r_rem <= step_rem;
                r_s0  <= step_s0;
                r_t0  <= step_t0;
            end else begin
                // remainder below divisor and nonzero: next division round
                r_rem <= r_den;
                r_den <= r_rem;
                r_s0  <= r_s1;
                r_s1  <= r_s0;
                r_t0  <= r_t1;
                r_t1  <= r_t0;
            end
        end
    end

endmodule

>>> test/tb_binary_poly_ext_euclid_inverse_unit.sv
// testbench for the gf(2) polynomial extended euclid and inverse unit
module tb_binary_poly_ext_euclid_inverse_unit;

    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 80;
    localparam int RAND_PER_PHASE = 475;

    typedef struct {
        bpe_pkg::t_in  operands;
        bpe_pkg::t_out result;
    } t_pending_result;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            in_valid = 1'b0;
    bpe_pkg::t_in    in_data = '0;
    logic            in_stall;
    logic            out_valid;
    bpe_pkg::t_out   out_data;
    logic            out_stall = 1'b0;

    bpe_pkg::t_in    operand_queue[$];
    t_pending_result euclid_results[$];

    int offered_cnt = 0;
    int accepted_cnt = 0;
    int mismatch_cnt = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    binary_poly_ext_euclid_inverse_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int poly_deg(bpe_pkg::t_poly v);
        int d;
        d = -1;
        for (int k = 0; k < bpe_pkg::POLY_WIDTH; k++) begin
            if (v[k]) d = k;
        end
        return d;
    endfunction

    function automatic void poly_divmod(input bpe_pkg::t_poly num,
                                        input bpe_pkg::t_poly den,
                                        output bpe_pkg::t_poly quo,
                                        output bpe_pkg::t_poly rem);
        int dd;
        int dn;
        bpe_pkg::t_poly n;
        n = num;
        quo = '0;
        dd = poly_deg(den);
        dn = poly_deg(n);
        while (dd >= 0 && dn >= dd) begin
            quo[dn - dd] = 1'b1;
            n ^= den << (dn - dd);
            dn = poly_deg(n);
        end
        rem = n;
    endfunction

    // carry-less product, truncated to the polynomial width
    function automatic bpe_pkg::t_poly poly_clmul(bpe_pkg::t_poly x, bpe_pkg::t_poly y);
        bpe_pkg::t_poly acc;
        acc = '0;
        for (int k = 0; k < bpe_pkg::POLY_WIDTH; k++) begin
            if (y[k]) acc ^= x << k;
        end
        return acc;
    endfunction

    function automatic bpe_pkg::t_out gf2_euclid_result(bpe_pkg::t_in item);
        bpe_pkg::t_poly r_prev, r_cur, quo, rem;
        bpe_pkg::t_poly s_prev, s_cur, t_prev, t_cur, s_next, t_next;
        bpe_pkg::t_out res;
        res = '0;
        if (item.op_b == '0) begin
            res.div_zero = 1'b1;
            return res;
        end
        r_prev = item.op_a;
        r_cur  = item.op_b;
        s_prev = bpe_pkg::t_poly'(1);
        t_prev = '0;
        s_cur  = '0;
        t_cur  = bpe_pkg::t_poly'(1);
        poly_divmod(r_prev, r_cur, quo, rem);
        // degree of the remainder drops every round, so this ends
        while (rem != '0) begin
            s_next = s_prev ^ poly_clmul(quo, s_cur);
            t_next = t_prev ^ poly_clmul(quo, t_cur);
            s_prev = s_cur;
            s_cur  = s_next;
            t_prev = t_cur;
            t_cur  = t_next;
            r_prev = r_cur;
            r_cur  = rem;
            poly_divmod(r_prev, r_cur, quo, rem);
        end
        res.gcd_poly    = r_cur;
        res.coef_a      = s_cur;
        res.coef_b      = t_cur;
        res.has_inverse = (r_cur == bpe_pkg::t_poly'(1));
        res.inverse     = res.has_inverse ? s_cur : '0;
        return res;
    endfunction

    function automatic bpe_pkg::t_poly low_poly(int bits);
        return bpe_pkg::t_poly'($urandom_range(0, (1 << bits) - 1));
    endfunction

    function automatic bpe_pkg::t_in random_operands();
        bpe_pkg::t_in item;
        bpe_pkg::t_poly g;
        item.op_a = bpe_pkg::t_poly'($urandom);
        item.op_b = bpe_pkg::t_poly'($urandom);
        case ($urandom_range(0, 9))
            0: item.op_b = low_poly($urandom_range(1, 8));
            1: item.op_b = '0;
            2: item.op_b = bpe_pkg::t_poly'(1);
            3: item.op_a = poly_clmul(item.op_b, low_poly($urandom_range(1, 8)));
            4: begin
                // shared factor so the gcd is not trivial
                g = low_poly(6) | bpe_pkg::t_poly'(2);
                item.op_a = poly_clmul(g, low_poly(9));
                item.op_b = poly_clmul(g, low_poly(9) | bpe_pkg::t_poly'(1));
            end
            5: item.op_a = '0;
            6: item.op_b[bpe_pkg::POLY_WIDTH-1] = 1'b1;
            7: begin
                item.op_a = bpe_pkg::t_poly'(1)
                            << $urandom_range(0, bpe_pkg::POLY_WIDTH - 1);
                item.op_b = (bpe_pkg::t_poly'(1)
                             << $urandom_range(0, bpe_pkg::POLY_WIDTH - 1))
                            ^ (bpe_pkg::t_poly'(1)
                               << $urandom_range(0, bpe_pkg::POLY_WIDTH - 1));
            end
            8: item.op_a = low_poly($urandom_range(1, 12));
            default: ;
        endcase
        return item;
    endfunction

    task automatic push_pair(bpe_pkg::t_poly a, bpe_pkg::t_poly b);
        bpe_pkg::t_in item;
        item.op_a = a;
        item.op_b = b;
        operand_queue.push_back(item);
    endtask

    task automatic wait_all_done();
        while (operand_queue.size() != 0 || accepted_cnt != offered_cnt
               || euclid_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // driver: inputs move on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!(in_valid && accepted_cnt != offered_cnt)) begin
            if (operand_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_data  <= operand_queue.pop_front();
                in_valid <= 1'b1;
                offered_cnt++;
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= i_rst_n && ($urandom_range(0, 99) < recv_stall_pct);
    end

    // monitor: both channels sampled on the rising edge
    always @(posedge i_clk) begin
        t_pending_result want;
        logic progress;
        progress = 1'b0;
        if (i_rst_n) begin
            if (in_valid && !in_stall) begin
                want.operands = in_data;
                want.result   = gf2_euclid_result(in_data);
                euclid_results.push_back(want);
                accepted_cnt++;
                progress = 1'b1;
            end
            if (out_valid && !out_stall) begin
                progress = 1'b1;
                if (euclid_results.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result item %p", out_data);
                end else begin
                    want = euclid_results.pop_front();
                    if (out_data.gcd_poly !== want.result.gcd_poly
                        || out_data.coef_a !== want.result.coef_a
                        || out_data.coef_b !== want.result.coef_b
                        || out_data.inverse !== want.result.inverse
                        || out_data.has_inverse !== want.result.has_inverse
                        || out_data.div_zero !== want.result.div_zero) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("mismatch a=%h b=%h", want.operands.op_a,
                                     want.operands.op_b);
                            $display("  expected gcd=%h ca=%h cb=%h inv=%h hi=%b dz=%b",
                                     want.result.gcd_poly, want.result.coef_a,
                                     want.result.coef_b, want.result.inverse,
                                     want.result.has_inverse, want.result.div_zero);
                            $display("  actual   gcd=%h ca=%h cb=%h inv=%h hi=%b dz=%b",
                                     out_data.gcd_poly, out_data.coef_a,
                                     out_data.coef_b, out_data.inverse,
                                     out_data.has_inverse, out_data.div_zero);
                        end
                    end
                end
            end
            if (progress) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("tb_binary_poly_ext_euclid_inverse_unit NOT OK");
                    $finish;
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed items: extremes, zero and unit modulus, exact division
        push_pair(16'h0000, 16'h0000);
        push_pair(16'hffff, 16'h0000);
        push_pair(16'h0000, 16'h0001);
        push_pair(16'hffff, 16'h0001);
        push_pair(16'h0000, 16'hffff);
        push_pair(16'hffff, 16'hffff);
        push_pair(16'h8000, 16'h8000);
        push_pair(16'h0001, 16'h8000);
        push_pair(16'h8000, 16'h0001);
        push_pair(16'h0001, 16'hffff);
        push_pair(16'h0053, 16'h011b);
        push_pair(16'h00ca, 16'h011b);
        push_pair(16'h0009, 16'h0003);
        push_pair(16'h0006, 16'h000a);
        push_pair(16'haaaa, 16'h5555);
        push_pair(16'h5555, 16'haaaa);
        push_pair(16'h0002, 16'h0003);
        push_pair(16'h7fff, 16'h8001);
        push_pair(16'h0001, 16'h0002);
        push_pair(16'h1234, 16'h002b);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            for (int n = 0; n < RAND_PER_PHASE; n++)
                operand_queue.push_back(random_operands());
            // sender holds off until every result is back
            wait_all_done();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && euclid_results.size() == 0) begin
            $display("tb_binary_poly_ext_euclid_inverse_unit OK");
        end else begin
            $display("tb_binary_poly_ext_euclid_inverse_unit NOT OK");
        end
        $finish;
    end

endmodule

>>> binary_poly_ext_euclid_inverse_unit.f
src/bpe_pkg.sv
src/bpe_step.sv
src/binary_poly_ext_euclid_inverse_unit.sv
test/tb_binary_poly_ext_euclid_inverse_unit.sv
